>>> rtl/ognb_pkg.sv
// ----------------------------------------------------------------------------
// ognb_pkg: shared types and constants for the occupancy grid engine
// Function codes, controller states and neighbor direction tables.
// ----------------------------------------------------------------------------
package ognb_pkg;

  typedef enum logic [2:0] {
    FN_SET   = 3'd0,
    FN_RECT  = 3'd1,
    FN_DISC  = 3'd2,
    FN_CLEAR = 3'd3,
    FN_QUERY = 3'd4,
    FN_NBR4  = 3'd5,
    FN_NBR8  = 3'd6,
    FN_NONE  = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SWEEP,
    ST_READ,
    ST_EVAL,
    ST_EMIT
  } state_t;

  localparam int REG_ROWS = 0;
  localparam int REG_COLS = 1;

  // 8-neighbor order: row-major over the 3x3 window with the centre skipped
  function automatic logic signed [1:0] dir8_r(input logic [2:0] i);
    case (i)
      3'd0, 3'd1, 3'd2: dir8_r = -2'sd1;
      3'd3, 3'd4:       dir8_r = 2'sd0;
      default:          dir8_r = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] dir8_c(input logic [2:0] i);
    case (i)
      3'd0, 3'd3, 3'd5: dir8_c = -2'sd1;
      3'd1, 3'd6:       dir8_c = 2'sd0;
      default:          dir8_c = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] dir4_r(input logic [2:0] i);
    case (i)
      3'd0:    dir4_r = -2'sd1;
      3'd1:    dir4_r = 2'sd1;
      default: dir4_r = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir4_c(input logic [2:0] i);
    case (i)
      3'd2:    dir4_c = -2'sd1;
      3'd3:    dir4_c = 2'sd1;
      default: dir4_c = 2'sd0;
    endcase
  endfunction

endpackage

>>> rtl/ognb_if.sv
// ----------------------------------------------------------------------------
// ognb_in_if / ognb_out_if: valid/ready channels
// One word moves per cycle where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ognb_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          func;
  logic signed [7:0]   row;
  logic signed [7:0]   col;
  logic [6:0]          height;
  logic [6:0]          width;
  logic [5:0]          radius;
  logic                blocked;
  modport source (output valid, func, row, col, height, width, radius, blocked,
                  input ready);
  modport sink   (input valid, func, row, col, height, width, radius, blocked,
                  output ready);
endinterface

interface ognb_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] nbr_row;
  logic [5:0] nbr_col;
  logic [2:0] direction;
  logic       found;
  logic       cell_free;
  logic       last;
  modport source (output valid, nbr_row, nbr_col, direction, found, cell_free,
                  last, input ready);
  modport sink   (input valid, nbr_row, nbr_col, direction, found, cell_free,
                  last, output ready);
endinterface

>>> rtl/ognb_ram.sv
// ----------------------------------------------------------------------------
// ognb_ram: generic single-port-write, one-read RAM
// Registered read: rdata follows raddr in the next cycle.
// ----------------------------------------------------------------------------
module ognb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/occupancy_grid_neighbor_engine.sv
// ----------------------------------------------------------------------------
// occupancy_grid_neighbor_engine: obstacle bitmap with neighbor expansion
// One-bit map in a RAM, one cell per row*MAX_COLS+col entry.
// ----------------------------------------------------------------------------
// The map sits in one RAM word per cell. After reset a clearing pass walks
// all MAX_ROWS*MAX_COLS entries, one a cycle, with the input held off.
// Clear all repeats that pass. Set cell is the accept and then one write.
// Query reads the 3x3 window up to its centre, one RAM read a cycle.
// Neighbor lists read the full window. They then scan one direction a cycle
// (4 or 8) and emit one word per free neighbor, a diagonal only when both
// cells beside it are free, or one word with found low when none is free.
// A busy output register holds the scan. Rectangle and disc fills walk
// their bounding box one cell a cycle; an empty rectangle writes nothing.
// A new word is taken only once the engine is idle and the last result
// has been taken.
module occupancy_grid_neighbor_engine
  import ognb_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  ognb_in_if.sink     in_ch,
  ognb_out_if.source  out_ch
);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  logic [6:0] rows_in_use, cols_in_use;
  state_t state, state_next;

  // latched item
  func_t             fn;
  logic signed [9:0] base_r, base_c;   // item origin
  logic signed [9:0] cur_r, cur_c;     // walk position
  logic signed [9:0] end_r, end_c;     // inclusive walk limits
  logic [11:0]       rad2;
  logic              blk;
  logic [AW:0]       sweep;
  logic [3:0]        win;              // window read index 0..9
  logic [8:0]        wfree;            // free flags of 3x3 window
  logic [2:0]        oidx;             // emit scan index
  logic              any;

  // effective limits
  logic [10:0] eff_r, eff_c;
  always_comb begin
    eff_r = (11'(rows_in_use) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(rows_in_use);
    eff_c = (11'(cols_in_use) > 11'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(cols_in_use);
  end

  function automatic logic valid_rc(input logic signed [9:0] r, input logic signed [9:0] c,
                                    input logic [10:0] er, input logic [10:0] ec);
    valid_rc = (r >= 0) && (11'(unsigned'(r)) < er) && (c >= 0) && (11'(unsigned'(c)) < ec);
  endfunction

  // window index -> row / column offset
  function automatic logic signed [1:0] win_dr(input logic [3:0] w);
    case (w) inside
      [4'd0:4'd2]: win_dr = -2'sd1;
      [4'd3:4'd5]: win_dr = 2'sd0;
      default:     win_dr = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] win_dc(input logic [3:0] w);
    case (w) inside
      4'd0, 4'd3, 4'd6: win_dc = -2'sd1;
      4'd1, 4'd4, 4'd7: win_dc = 2'sd0;
      default:          win_dc = 2'sd1;
    endcase
  endfunction

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'd64;
      cols_in_use <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_ROWS)) rows_in_use <= cfg_data;
      else cols_in_use <= cfg_data;
    end
  end

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic          wdata, rdata;

  ognb_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // window cell under read: win 0..9 -> offset, 9 reading cell 8 again
  logic signed [9:0] rd_r, rd_c, pv_r, pv_c;
  logic              pv_ok;
  logic [3:0]        pwin;
  always_comb begin
    rd_r = base_r + 10'(win_dr(win));
    rd_c = base_c + 10'(win_dc(win));
    pv_r = base_r + 10'(win_dr(pwin));
    pv_c = base_c + 10'(win_dc(pwin));
    pv_ok = valid_rc(pv_r, pv_c, eff_r, eff_c);
  end

  function automatic logic [AW-1:0] addr_of(input logic signed [9:0] r,
                                            input logic signed [9:0] c);
    addr_of = AW'(unsigned'(r[RW-1:0])) * AW'(MAX_COLS) + AW'(unsigned'(c[CW-1:0]));
  endfunction

  // disc test on walk position
  logic signed [9:0] dr, dc;
  logic [19:0]       d2;
  logic              cur_ok;
  always_comb begin
    dr = cur_r - base_r;
    dc = cur_c - base_c;
    d2 = 20'(dr * dr) + 20'(dc * dc);
    cur_ok = valid_rc(cur_r, cur_c, eff_r, eff_c);
  end

  // neighbor pick for emit step
  logic [2:0]        dsel;
  logic signed [1:0] odr, odc;
  logic [3:0]        wi;
  logic              keep;
  logic [3:0]        mr, mc;
  always_comb begin
    dsel = oidx;
    if (fn == FN_NBR4) begin
      odr = dir4_r(dsel); odc = dir4_c(dsel);
    end else begin
      odr = dir8_r(dsel); odc = dir8_c(dsel);
    end
    wi = 4'((odr + 2'sd1) * 3) + 4'(odc + 2'sd1);
    mr = 4'((odr + 2'sd1) * 3) + 4'd1;
    mc = 4'd3 + 4'(odc + 2'sd1);
    keep = wfree[wi] && ((odr == 0) || (odc == 0) || (wfree[mr] && wfree[mc]));
  end

  logic [2:0] last_idx;
  assign last_idx = (fn == FN_NBR4) ? 3'd3 : 3'd7;

  // output register
  logic       ovalid;
  logic [5:0] o_r, o_c;
  logic [2:0] o_d;
  logic       o_f, o_cf, o_l;

  assign out_ch.valid = ovalid;
  assign out_ch.nbr_row = o_r;
  assign out_ch.nbr_col = o_c;
  assign out_ch.direction = o_d;
  assign out_ch.found = o_f;
  assign out_ch.cell_free = o_cf;
  assign out_ch.last = o_l;

  logic oslot;
  assign oslot = !ovalid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && !ovalid;

  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // a result word is loaded this cycle
  logic emit;
  assign emit = (state == ST_EMIT) && oslot &&
                ((fn == FN_QUERY) || keep || ((oidx == last_idx) && !any));

  // next state and RAM control
  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = addr_of(cur_r, cur_c);
    wdata = 1'b1;
    raddr = addr_of(rd_r, rd_c);
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (func_t'(in_ch.func))
            FN_SET, FN_RECT, FN_DISC: state_next = ST_WALK;
            FN_CLEAR:                 state_next = ST_SWEEP;
            FN_QUERY, FN_NBR4, FN_NBR8: state_next = ST_READ;
            default:                  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        we = 1'b1;
        waddr = sweep[AW-1:0];
        wdata = 1'b0;
        if (sweep == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_WALK: begin
        wdata = (fn == FN_SET) ? blk : 1'b1;
        // empty box: nothing to write
        we = cur_ok && (cur_r <= end_r) && (cur_c <= end_c) &&
             ((fn != FN_DISC) || (d2 <= 20'(rad2)));
        if (cur_r > end_r || cur_c > end_c || (cur_r == end_r && cur_c == end_c))
          state_next = ST_IDLE;
      end
      ST_READ: begin
        if (fn == FN_QUERY) begin
          if (win == 4'd5) state_next = ST_EMIT;
        end else if (win == 4'd9) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (oslot && (fn == FN_QUERY || keep || oidx == last_idx)) begin
          if (fn == FN_QUERY) state_next = ST_IDLE;
          else if (oidx == last_idx) state_next = ST_IDLE;
        end else if (!oslot) begin
          state_next = ST_EMIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // more free neighbors beyond oidx?
  logic more;
  always_comb begin
    more = 1'b0;
    for (int k = 0; k < 8; k++) begin
      logic signed [1:0] kr, kc;
      logic [3:0] ki, kmr, kmc;
      kr = (fn == FN_NBR4) ? dir4_r(3'(k)) : dir8_r(3'(k));
      kc = (fn == FN_NBR4) ? dir4_c(3'(k)) : dir8_c(3'(k));
      ki = 4'((kr + 2'sd1) * 3) + 4'(kc + 2'sd1);
      kmr = 4'((kr + 2'sd1) * 3) + 4'd1;
      kmc = 4'd3 + 4'(kc + 2'sd1);
      if (3'(k) > oidx && 3'(k) <= last_idx && wfree[ki] &&
          ((kr == 0) || (kc == 0) || (wfree[kmr] && wfree[kmc])))
        more = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      sweep <= '0;
      ovalid <= 1'b0;
      win <= '0;
      pwin <= '0;
      oidx <= '0;
      any <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          sweep <= '0;
          win <= '0;
          oidx <= '0;
          any <= 1'b0;
          wfree <= '0;
        end
        ST_SWEEP: sweep <= sweep + 1'b1;
        ST_READ: begin
          win <= win + 4'd1;
          pwin <= win;
          if (win != 4'd0) wfree[pwin] <= pv_ok && !rdata;
        end
        ST_EMIT: begin
          if (oslot) begin
            if (fn == FN_QUERY) begin
              {o_r, o_c, o_d, o_f} <= '0;
              o_cf <= wfree[4];
              o_l <= 1'b1;
            end else if (keep) begin
              o_r <= 6'(base_r + 10'(odr));
              o_c <= 6'(base_c + 10'(odc));
              o_d <= oidx;
              o_f <= 1'b1;
              o_cf <= 1'b0;
              o_l <= !more;
              any <= 1'b1;
              oidx <= oidx + 3'd1;
            end else if (oidx == last_idx) begin
              if (!any) begin
                {o_r, o_c, o_d, o_f, o_cf} <= '0;
                o_l <= 1'b1;
              end
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // item capture and walk position
  always_ff @(posedge clk) begin
    if (acc) begin
      fn <= func_t'(in_ch.func);
      blk <= in_ch.blocked;
      base_r <= 10'(in_ch.row);
      base_c <= 10'(in_ch.col);
      rad2 <= 12'(in_ch.radius) * 12'(in_ch.radius);
      case (func_t'(in_ch.func))
        FN_RECT: begin
          cur_r <= 10'(in_ch.row);
          cur_c <= 10'(in_ch.col);
          end_r <= 10'(in_ch.row) + 10'(in_ch.height) - 10'sd1;
          end_c <= 10'(in_ch.col) + 10'(in_ch.width) - 10'sd1;
        end
        FN_DISC: begin
          cur_r <= 10'(in_ch.row) - 10'(in_ch.radius);
          cur_c <= 10'(in_ch.col) - 10'(in_ch.radius);
          end_r <= 10'(in_ch.row) + 10'(in_ch.radius);
          end_c <= 10'(in_ch.col) + 10'(in_ch.radius);
        end
        default: begin
          cur_r <= 10'(in_ch.row);
          cur_c <= 10'(in_ch.col);
          end_r <= 10'(in_ch.row);
          end_c <= 10'(in_ch.col);
        end
      endcase
    end else if (state == ST_WALK) begin
      if (cur_c >= end_c) begin
        // row wrap: restart at left edge of box
        cur_c <= (fn == FN_DISC) ? base_c - (end_c - base_c) : base_c;
        cur_r <= cur_r + 10'sd1;
      end else begin
        cur_c <= cur_c + 10'sd1;
      end
    end
  end

  // For a query only the centre (index 4) matters; reads 0..5 are harmless.

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !out_ch.ready) |=> ovalid) else $error("result dropped");
  a_no_write_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT || state == ST_READ) |-> !we) else $error("write in read phase");
`endif
endmodule
